### rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside reset.
`define FFSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define FFSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/ffsa_pkg.sv
// Types and constants of the first-fit segment allocator.
package ffsa_pkg;

    localparam logic [6:0] LINK_NULL = 7'd127;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_EVAL,
        S_EVALNX,
        S_WR_NEW,
        S_WR_CUR,
        S_WR_NX,
        S_FINISH
    } t_state;

    // One segment record as held in the record memory.
    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] length;
        logic        is_free;
        logic [6:0]  link;
    } t_rec;

    // Result of the size rounding and spare record search.
    typedef struct packed {
        logic        done;
        logic [16:0] need;
        logic        spare_ok;
        logic [5:0]  spare;
    } t_prep;

endpackage

### rtl/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator: walk controller and result register.
//
// Usage: one request channel (i_in_valid / o_in_stall with i_cmd, i_request_size,
// i_payload_address) and one result channel (o_out_valid / i_out_stall with
// o_status, o_granted_address). Each request gives exactly one result.
// An allocate request first rounds its size and finds a spare record, then walks
// the segment chain from record 0 one record per cycle through the record memory
// read port; on a fit it writes the split-off tail, if any, then the found record.
// A free walks the same way, reads the successor of the hit segment when it has
// one, and writes the freed record and, with a merge, the absorbed successor. The
// walk visits at most MAX_SEGMENTS records; a free of the null address answers
// without walking the chain.
// One request is worked at a time; the next one can be taken in the cycle after the
// result is loaded, while that result waits, and the block holds its last step until
// the slot drains. While the receiver stalls, the result holds steady.
// Reset is synchronous: the chain becomes one free segment spanning the heap
// and the block is ready on the first cycle after reset.
`include "assert_macros.svh"

module first_fit_segment_allocator_unit #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 8,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [15:0] i_request_size,
    input  logic [15:0] i_payload_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_granted_address
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);

    ffsa_pkg::t_state  r_state, n_state;
    ffsa_pkg::t_cmd    r_cmd, n_cmd;
    logic [15:0]       r_addr, n_addr;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_nx, n_nx;
    logic [6:0]        r_steps, n_steps;
    ffsa_pkg::t_rec    r_rec, n_rec;
    ffsa_pkg::t_rec    r_nxrec, n_nxrec;
    logic [16:0]       r_need, n_need;
    logic [IDX_W-1:0]  r_spare, n_spare;
    logic              r_spare_ok, n_spare_ok;
    logic              r_merge, n_merge;
    logic [MAX_SEGMENTS-1:0] r_in_use, n_in_use;
    ffsa_pkg::t_status r_status, n_status;
    logic [15:0]       r_grant, n_grant;
    logic              r_out_valid, n_out_valid;
    ffsa_pkg::t_status r_out_status, n_out_status;
    logic [15:0]       r_out_grant, n_out_grant;

    logic              w_in_accept;
    logic              w_out_free;
    logic              w_prep_start;
    ffsa_pkg::t_prep   w_prep;
    logic [63:0]       w_use_pad;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    ffsa_pkg::t_rec    w_wr_data;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    ffsa_pkg::t_rec    w_rd;
    logic              w_link_ok;
    logic [IDX_W-1:0]  w_link_idx;
    logic [6:0]        w_visit;
    logic              w_more;
    logic              w_fit;
    logic              w_hit;
    logic              w_split;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Pad the in-use map with ones past the last record.
    always_comb begin
        w_use_pad = '1;
        w_use_pad[MAX_SEGMENTS-1:0] = r_in_use;
    end

    ffsa_prep #(
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_prep_start),
        .i_req     (i_request_size),
        .i_use_pad (w_use_pad),
        .o_prep    (w_prep)
    );

    ffsa_rec_mem #(
        .DEPTH    (MAX_SEGMENTS),
        .IDX_W    (IDX_W),
        .INIT_LEN (HEAP_BYTES - HEADER_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd)
    );

    // Judge the record just read.
    always_comb begin
        w_link_ok  = w_rd.link < 7'(MAX_SEGMENTS);
        w_link_idx = w_rd.link[IDX_W-1:0];
        w_visit    = r_steps + 7'd1;
        w_more     = w_link_ok && (w_visit < 7'(MAX_SEGMENTS));
        w_fit      = w_rd.is_free && ({1'b0, w_rd.length} >= r_need);
        w_split    = r_spare_ok && ({2'b00, w_rd.length} >=
                     ({1'b0, r_need} + 18'(HEADER_BYTES + ALIGN_BYTES)));
        w_hit      = ({1'b0, w_rd.offset} + 17'(HEADER_BYTES)) == {1'b0, r_addr};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    if (ffsa_pkg::t_cmd'(i_cmd) == ffsa_pkg::CMD_ALLOC) begin
                        n_state = ffsa_pkg::S_PREP;
                    end else if (i_payload_address == 16'd0) begin
                        n_state = ffsa_pkg::S_FINISH;
                    end else begin
                        n_state = ffsa_pkg::S_EVAL;
                    end
                end
            end
            ffsa_pkg::S_PREP: begin
                if (w_prep.done) begin
                    n_state = ffsa_pkg::S_EVAL;
                end
            end
            ffsa_pkg::S_EVAL: begin
                if (r_cmd == ffsa_pkg::CMD_ALLOC && w_fit) begin
                    n_state = w_split ? ffsa_pkg::S_WR_NEW : ffsa_pkg::S_WR_CUR;
                end else if (r_cmd == ffsa_pkg::CMD_FREE && w_hit) begin
                    n_state = (w_link_ok && w_link_idx != r_cur) ? ffsa_pkg::S_EVALNX
                                                                 : ffsa_pkg::S_WR_CUR;
                end else if (!w_more) begin
                    n_state = ffsa_pkg::S_FINISH;
                end
            end
            ffsa_pkg::S_EVALNX: n_state = ffsa_pkg::S_WR_CUR;
            ffsa_pkg::S_WR_NEW: n_state = ffsa_pkg::S_WR_CUR;
            ffsa_pkg::S_WR_CUR: n_state = r_merge ? ffsa_pkg::S_WR_NX : ffsa_pkg::S_FINISH;
            ffsa_pkg::S_WR_NX:  n_state = ffsa_pkg::S_FINISH;
            ffsa_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = ffsa_pkg::S_IDLE;
                end
            end
            default: n_state = ffsa_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory control and result register.
    always_comb begin
        n_cmd        = r_cmd;
        n_addr       = r_addr;
        n_cur        = r_cur;
        n_nx         = r_nx;
        n_steps      = r_steps;
        n_rec        = r_rec;
        n_nxrec      = r_nxrec;
        n_need       = r_need;
        n_spare      = r_spare;
        n_spare_ok   = r_spare_ok;
        n_merge      = r_merge;
        n_in_use     = r_in_use;
        n_status     = r_status;
        n_grant      = r_grant;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        w_prep_start = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_cur;
        w_wr_data    = r_rec;

        unique case (r_state)
            ffsa_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_cmd   = ffsa_pkg::t_cmd'(i_cmd);
                    n_addr  = i_payload_address;
                    n_cur   = '0;
                    n_steps = 7'd0;
                    n_merge = 1'b0;
                    n_status = ffsa_pkg::ST_OK;
                    n_grant  = 16'd0;
                    if (ffsa_pkg::t_cmd'(i_cmd) == ffsa_pkg::CMD_ALLOC) begin
                        w_prep_start = 1'b1;
                    end else if (i_payload_address != 16'd0) begin
                        w_rd_en = 1'b1;
                    end
                end
            end
            ffsa_pkg::S_PREP: begin
                if (w_prep.done) begin
                    w_rd_en    = 1'b1;
                    n_need     = w_prep.need;
                    n_spare    = IDX_W'(w_prep.spare);
                    n_spare_ok = w_prep.spare_ok;
                end
            end
            ffsa_pkg::S_EVAL: begin
                if (r_cmd == ffsa_pkg::CMD_ALLOC && w_fit) begin
                    n_rec         = w_rd;
                    n_rec.is_free = 1'b0;
                    n_status      = ffsa_pkg::ST_OK;
                    n_grant       = w_rd.offset + 16'(HEADER_BYTES);
                end else if (r_cmd == ffsa_pkg::CMD_FREE && w_hit) begin
                    n_rec         = w_rd;
                    n_rec.is_free = 1'b1;
                    n_nx          = w_link_idx;
                    n_status      = ffsa_pkg::ST_OK;
                    n_grant       = 16'd0;
                    if (w_link_ok && w_link_idx != r_cur) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_link_idx;
                    end
                end else if (w_more) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = w_link_idx;
                    n_cur     = w_link_idx;
                    n_steps   = w_visit;
                end else begin
                    n_status = (r_cmd == ffsa_pkg::CMD_ALLOC) ? ffsa_pkg::ST_NOMEM
                                                              : ffsa_pkg::ST_NOTFOUND;
                    n_grant  = 16'd0;
                end
            end
            ffsa_pkg::S_EVALNX: begin
                // Absorb the following segment when it is free.
                if (w_rd.is_free) begin
                    n_merge      = 1'b1;
                    n_nxrec      = w_rd;
                    n_rec.length = r_rec.length + 16'(HEADER_BYTES) + w_rd.length;
                    n_rec.link   = w_rd.link;
                end
            end
            ffsa_pkg::S_WR_NEW: begin
                // Split off the tail as a new free segment.
                w_wr_en           = 1'b1;
                w_wr_addr         = r_spare;
                w_wr_data.offset  = r_rec.offset + 16'(HEADER_BYTES) + r_need[15:0];
                w_wr_data.length  = 16'({1'b0, r_rec.length} - r_need
                                        - 17'(HEADER_BYTES));
                w_wr_data.is_free = 1'b1;
                w_wr_data.link    = r_rec.link;
                n_in_use[r_spare] = 1'b1;
                n_rec.link        = 7'(r_spare);
                n_rec.length      = r_need[15:0];
            end
            ffsa_pkg::S_WR_CUR: begin
                w_wr_en = 1'b1;
            end
            ffsa_pkg::S_WR_NX: begin
                w_wr_en           = 1'b1;
                w_wr_addr         = r_nx;
                w_wr_data         = r_nxrec;
                w_wr_data.link    = ffsa_pkg::LINK_NULL;
                w_wr_data.is_free = 1'b0;
                n_in_use[r_nx]    = 1'b0;
            end
            ffsa_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_grant  = r_grant;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffsa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_in_use    <= MAX_SEGMENTS'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_in_use    <= n_in_use;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_addr       <= n_addr;
        r_cur        <= n_cur;
        r_nx         <= n_nx;
        r_steps      <= n_steps;
        r_rec        <= n_rec;
        r_nxrec      <= n_nxrec;
        r_need       <= n_need;
        r_spare      <= n_spare;
        r_spare_ok   <= n_spare_ok;
        r_merge      <= n_merge;
        r_status     <= n_status;
        r_grant      <= n_grant;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
    end

    assign o_in_stall        = (r_state != ffsa_pkg::S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_address = r_out_grant;

    // Checks.
    `FFSA_ASSERT(a_head_in_use, r_in_use[0], "head record left the chain")
    `FFSA_ASSERT(a_fail_no_grant, o_out_valid && o_status != ffsa_pkg::ST_OK |-> o_granted_address == 16'd0, "failed request carries an address")
    `FFSA_ASSERT(a_accept_busy, w_in_accept |=> r_state != ffsa_pkg::S_IDLE, "accepted request did not start")
    `FFSA_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result present after reset")

endmodule

### rtl/ffsa_rec_mem.sv
// Segment record memory, one write and one registered read port.
module ffsa_rec_mem #(
    parameter int DEPTH    = 64,
    parameter int IDX_W    = 6,
    parameter int INIT_LEN = 65512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  ffsa_pkg::t_rec    i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output ffsa_pkg::t_rec    o_rd_data
);

    ffsa_pkg::t_rec r_mem [DEPTH];
    ffsa_pkg::t_rec r_rd_data;

    // Write; during reset seed the head record with the whole heap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem[0] <= '{offset: 16'd0, length: 16'(INIT_LEN), is_free: 1'b1,
                          link: ffsa_pkg::LINK_NULL};
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ffsa_prep.sv
// Size rounding and spare record search, one record group of four per cycle.
module ffsa_prep #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [15:0]     i_req,
    input  logic [63:0]     i_use_pad,
    output ffsa_pkg::t_prep o_prep
);

    // Reciprocal of the alignment, exact for any 16-bit size.
    localparam int RCP_SH = 16 + $clog2(ALIGN_BYTES);
    localparam int RCP_M  = (1 << RCP_SH) / ALIGN_BYTES + 1;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [15:0] r_req;
    logic [15:0] r_quo;
    logic [5:0]  r_rem;
    logic        r_found;
    logic [5:0]  r_spare;

    logic [33:0] w_prod;
    logic [15:0] w_quo;
    logic [5:0]  w_rem;
    logic [3:0]  w_grp;
    logic        w_zero;
    logic [1:0]  w_pos;

    // Quotient by reciprocal multiplication, remainder from the held quotient.
    always_comb begin
        w_prod = {18'd0, r_req} * 34'(RCP_M);
        w_quo  = 16'(w_prod >> RCP_SH);
        w_rem  = 6'(r_req - 16'(r_quo * 16'(ALIGN_BYTES)));
    end

    // Find the first unused record in the current group of four.
    always_comb begin
        w_grp  = i_use_pad[{r_cnt, 2'b00} +: 4];
        w_zero = 1'b0;
        w_pos  = 2'd0;
        for (int j = 3; j >= 0; j--) begin
            if (!w_grp[j]) begin
                w_zero = 1'b1;
                w_pos  = 2'(j);
            end
        end
    end

    // Sequence the sixteen steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == 4'd15) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt   <= 4'd0;
            r_req   <= i_req;
            r_rem   <= 6'd0;
            r_found <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd0) begin
                r_quo <= w_quo;
            end
            if (r_cnt == 4'd1) begin
                r_rem <= w_rem;
            end
            if (!r_found && w_zero) begin
                r_found <= 1'b1;
                r_spare <= {r_cnt, w_pos};
            end
        end
    end

    // Round up to the alignment.
    always_comb begin
        o_prep.done     = r_done;
        o_prep.need     = (r_rem == 6'd0) ? {1'b0, r_req}
                        : {1'b0, r_req} + (17'(ALIGN_BYTES) - {11'd0, r_rem});
        o_prep.spare_ok = r_found;
        o_prep.spare    = r_spare;
    end

endmodule

### sim/testbench.sv
// Testbench of the first-fit segment allocator: request driver, result monitor, predictor.
`timescale 1ns / 1ps

module testbench;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 24;
    localparam int ALIGN_BYTES  = 8;
    localparam int MAX_SEGMENTS = 64;
    localparam int CYCLE_LIMIT  = 2000000;

    typedef struct packed {
        ffsa_pkg::t_cmd cmd;
        logic [15:0]    size;
        logic [15:0]    addr;
    } t_request;

    typedef struct packed {
        ffsa_pkg::t_status status;
        logic [15:0]       granted;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_cmd;
    logic [15:0] i_request_size;
    logic [15:0] i_payload_address;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic [15:0] o_granted_address;

    first_fit_segment_allocator_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_request_size(i_request_size),
        .i_payload_address(i_payload_address),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_granted_address(o_granted_address)
    );

    // Shadow copy of the segment chain.
    logic [15:0] seg_offset [MAX_SEGMENTS];
    logic [15:0] seg_length [MAX_SEGMENTS];
    logic        seg_free   [MAX_SEGMENTS];
    logic [6:0]  seg_link   [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] rec_used;

    t_request pending_requests [$];
    t_grant   expected_grants  [$];
    logic [15:0] live_addrs [$];
    int  errors = 0;
    int  cycles = 0;
    bit  stimulus_done = 0;
    bit  hold_sender = 0;
    bit  calm = 0;
    bit  in_taken = 0;

    function automatic void reset_chain();
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
            seg_offset[k] = '0;
            seg_length[k] = '0;
            seg_free[k]   = 1'b0;
            seg_link[k]   = ffsa_pkg::LINK_NULL;
        end
        seg_length[0] = 16'(HEAP_BYTES - HEADER_BYTES);
        seg_free[0]   = 1'b1;
        rec_used      = MAX_SEGMENTS'(1);
    endfunction

    // Walk the chain first-fit; split when a header plus one unit fits.
    function automatic t_grant allocate_segment(logic [15:0] size);
        int unsigned need, cur, nr;
        t_grant g;
        need = (int'(size) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
        cur = 0;
        for (int s = 0; s < MAX_SEGMENTS && cur < MAX_SEGMENTS; s++) begin
            if (seg_free[cur] && seg_length[cur] >= need) begin
                if (seg_length[cur] >= need + HEADER_BYTES + ALIGN_BYTES) begin
                    nr = MAX_SEGMENTS;
                    for (int k = MAX_SEGMENTS - 1; k >= 0; k--)
                        if (!rec_used[k]) nr = k;
                    if (nr < MAX_SEGMENTS) begin
                        seg_offset[nr] = 16'(seg_offset[cur] + HEADER_BYTES + need);
                        seg_length[nr] = 16'(seg_length[cur] - need - HEADER_BYTES);
                        seg_free[nr]   = 1'b1;
                        seg_link[nr]   = seg_link[cur];
                        rec_used[nr]   = 1'b1;
                        seg_link[cur]  = 7'(nr);
                        seg_length[cur] = 16'(need);
                    end
                end
                seg_free[cur] = 1'b0;
                g.status  = ffsa_pkg::ST_OK;
                g.granted = 16'(seg_offset[cur] + HEADER_BYTES);
                return g;
            end
            cur = seg_link[cur];
        end
        g.status  = ffsa_pkg::ST_NOMEM;
        g.granted = '0;
        return g;
    endfunction

    // Mark the segment free and merge forward only.
    function automatic t_grant release_segment(logic [15:0] addr);
        int unsigned cur, nx;
        t_grant g;
        g.granted = '0;
        g.status  = ffsa_pkg::ST_OK;
        if (addr == 0) return g;
        cur = 0;
        for (int s = 0; s < MAX_SEGMENTS && cur < MAX_SEGMENTS; s++) begin
            if (17'(seg_offset[cur]) + HEADER_BYTES == addr) begin
                nx = seg_link[cur];
                seg_free[cur] = 1'b1;
                if (nx < MAX_SEGMENTS && nx != cur && seg_free[nx]) begin
                    seg_length[cur] = 16'(seg_length[cur] + HEADER_BYTES + seg_length[nx]);
                    seg_link[cur]   = seg_link[nx];
                    seg_link[nx]    = ffsa_pkg::LINK_NULL;
                    seg_free[nx]    = 1'b0;
                    rec_used[nx]    = 1'b0;
                end
                return g;
            end
            cur = seg_link[cur];
        end
        g.status = ffsa_pkg::ST_NOTFOUND;
        return g;
    endfunction

    // Clock.
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: present requests at the falling edge, hold each until it is taken.
    always @(negedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_in_valid && !in_taken) begin
                // hold the stalled request
            end else if (pending_requests.size() > 0 && !hold_sender
                         && (calm || $urandom_range(99) >= 37)) begin
                i_in_valid        <= 1'b1;
                i_cmd             <= pending_requests[0].cmd;
                i_request_size    <= pending_requests[0].size;
                i_payload_address <= pending_requests[0].addr;
            end else begin
                i_in_valid <= 1'b0;
            end
            in_taken = 1'b0;
            i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 37);
        end
    end

    // Predict on acceptance and check results.
    always @(posedge i_clk) begin
        t_request rq;
        t_grant   exp_g;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                rq = pending_requests.pop_front();
                in_taken = 1'b1;
                if (rq.cmd == ffsa_pkg::CMD_ALLOC) begin
                    exp_g = allocate_segment(rq.size);
                    if (exp_g.status == ffsa_pkg::ST_OK) live_addrs.push_back(exp_g.granted);
                end else begin
                    exp_g = release_segment(rq.addr);
                end
                expected_grants.push_back(exp_g);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_grants.size() == 0) begin
                    $display("%0t: unexpected result status %0d addr %0h",
                             $time, o_status, o_granted_address);
                    errors++;
                end else begin
                    exp_g = expected_grants.pop_front();
                    if (o_status !== exp_g.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_g.status, o_status);
                        errors++;
                    end
                    if (o_granted_address !== exp_g.granted) begin
                        $display("%0t: granted_address expected %0h actual %0h",
                                 $time, exp_g.granted, o_granted_address);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_request(ffsa_pkg::t_cmd c, logic [15:0] s, logic [15:0] a);
        t_request r;
        r.cmd = c;
        r.size = s;
        r.addr = a;
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() > 0 || expected_grants.size() > 0)
            @(posedge i_clk);
    endtask

    // Random addresses: mostly previously granted ones, some noise.
    function automatic logic [15:0] pick_addr();
        int r;
        r = $urandom_range(99);
        if (r < 75 && live_addrs.size() > 0)
            return live_addrs[$urandom_range(live_addrs.size() - 1)];
        if (r < 82) return 16'd0;
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 16'($urandom_range(512));
        if (r < 90) return 16'($urandom_range(4096));
        return 16'($urandom);
    endfunction

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_cmd = 0;
        i_request_size = 0;
        i_payload_address = 0;
        i_out_stall = 0;
        reset_chain();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: size extremes, zero size, null and unknown free, double free, merges.
        push_request(ffsa_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
        push_request(ffsa_pkg::CMD_ALLOC, 16'd1, 16'h0);
        push_request(ffsa_pkg::CMD_ALLOC, 16'd8, 16'h0);
        push_request(ffsa_pkg::CMD_ALLOC, 16'd9, 16'h0);
        push_request(ffsa_pkg::CMD_ALLOC, 16'hFFFF, 16'h0);
        push_request(ffsa_pkg::CMD_FREE, 16'hFFFF, 16'd0);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'hFFFF);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'd24);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'd24);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'd48);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'd80);
        push_request(ffsa_pkg::CMD_ALLOC, 16'd40000, 16'h0);
        push_request(ffsa_pkg::CMD_ALLOC, 16'd30000, 16'h0);
        push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'd24);
        push_request(ffsa_pkg::CMD_ALLOC, 16'hAAAA, 16'h5555);
        push_request(ffsa_pkg::CMD_FREE, 16'h5555, 16'hAAAA);
        wait_drained();

        // Exhaust the record pool with tiny allocations, then free some.
        for (int k = 0; k < 70; k++) push_request(ffsa_pkg::CMD_ALLOC, 16'd1, 16'h0);
        for (int k = 0; k < 20; k++)
            push_request(ffsa_pkg::CMD_FREE, 16'h0, 16'(24 + 32 * $urandom_range(69)));
        wait_drained();

        // Sender pauses with nothing pending.
        hold_sender = 1;
        repeat (30) @(posedge i_clk);
        hold_sender = 0;

        // Random part, with a calm stretch in the middle.
        for (int n = 0; n < 1800; n++) begin
            if (n == 600) begin
                wait_drained();
                calm = 1;
            end
            if (n == 900) calm = 0;
            if ($urandom_range(99) < 55)
                push_request(ffsa_pkg::CMD_ALLOC, pick_size(), 16'($urandom));
            else
                push_request(ffsa_pkg::CMD_FREE, 16'($urandom), pick_addr());
            if (pending_requests.size() > 50) wait_drained();
        end
        wait_drained();
        repeat (200) @(posedge i_clk);
        stimulus_done = 1;
    end

    // Final verdict or timeout.
    always @(posedge i_clk) begin
        if (stimulus_done) begin
            if (errors == 0 && expected_grants.size() == 0) begin
                $display("testbench: PASS");
            end else begin
                $display("testbench: FAIL");
            end
            $finish;
        end else if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule

### files.f
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_rec_mem.sv
rtl/ffsa_prep.sv
rtl/first_fit_segment_allocator_unit.sv
sim/testbench.sv
